[src/assert_macros.svh]
// Assertion helpers. Both assume a clock named clk and an active-low reset named arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BES_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define BES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BES_ASSERT(lbl, prop)
`define BES_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/bes_pkg.sv]
package bes_pkg;

	localparam int TABLE_SIZE_DEF = 64;
	localparam int MAX_ITER_DEF   = 8;

	localparam int CODE_W   = 7;
	localparam int IDX_W    = 6;
	localparam int Q_W      = 17;
	localparam int TOL_W    = 16;
	localparam int VAL_W    = 24;
	localparam int PROD_W   = VAL_W + Q_W + 1;
	localparam int DEN_W    = VAL_W;
	localparam int DIV_BITS = VAL_W + 16;
	localparam int CODES    = 2 ** CODE_W;

	localparam logic [Q_W-1:0]   ONE_Q16   = 17'd65536;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

	typedef logic [Q_W-1:0] q16_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [CODES-1:0][Q_W-1:0] ctrl_tab_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_COEF,
		ST_MUL,
		ST_ADD,
		ST_CHECK,
		ST_DIV,
		ST_DONE
	} bes_state_t;

	typedef enum logic [1:0] {
		POLY_FX,
		POLY_DX,
		POLY_FY
	} bes_poly_t;

	// One slot of the divider chain; word holds the numerator bits still to be
	// consumed in its upper part and the quotient bits found so far in its lower part.
	typedef struct packed {
		logic                valid;
		logic                neg;
		logic [DEN_W-1:0]    rem;
		logic [DIV_BITS-1:0] word;
		logic [DEN_W-1:0]    den;
	} bes_div_t;

	// Control code to Q16, rounded to nearest; evaluated at elaboration only.
	function automatic ctrl_tab_t ctrl_table();
		ctrl_tab_t tab;
		for (int i = 0; i < CODES; i++) begin
			tab[i] = Q_W'((i * 65536 + 63) / 127);
		end
		return tab;
	endfunction

	localparam ctrl_tab_t CTRL_Q16 = ctrl_table();

endpackage

[src/bes_in_if.sv]
interface bes_in_if;
	logic                         valid;
	logic                         ready;
	logic [bes_pkg::CODE_W-1:0]   ctrl_x1;
	logic [bes_pkg::CODE_W-1:0]   ctrl_y1;
	logic [bes_pkg::CODE_W-1:0]   ctrl_x2;
	logic [bes_pkg::CODE_W-1:0]   ctrl_y2;
	logic [bes_pkg::IDX_W-1:0]    sample_index;

	modport source (output valid, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, sample_index,
		input ready);
	modport sink (input valid, ctrl_x1, ctrl_y1, ctrl_x2, ctrl_y2, sample_index,
		output ready);
endinterface

[src/bes_out_if.sv]
interface bes_out_if;
	logic                       valid;
	logic                       ready;
	logic [bes_pkg::Q_W-1:0]    curve_value;
	logic                       is_linear;
	logic [bes_pkg::IDX_W-1:0]  sample_echo;

	modport source (output valid, curve_value, is_linear, sample_echo, input ready);
	modport sink (input valid, curve_value, is_linear, sample_echo, output ready);
endinterface

[src/bes_div_cell.sv]
module bes_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  bes_pkg::bes_div_t din,
	output bes_pkg::bes_div_t dout
);

	logic [bes_pkg::DEN_W:0] trial;
	logic                    fits;
	bes_pkg::bes_div_t       nxt;
	bes_pkg::bes_div_t       data_q;
	logic                    valid_q;

	// One restoring step: bring down the next numerator bit and subtract if it fits.
	always_comb begin
		trial    = {din.rem, din.word[bes_pkg::DIV_BITS-1]};
		fits     = trial >= {1'b0, din.den};
		nxt      = din;
		nxt.rem  = fits ? bes_pkg::DEN_W'(trial - {1'b0, din.den})
			: trial[bes_pkg::DEN_W-1:0];
		nxt.word = {din.word[bes_pkg::DIV_BITS-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= nxt;
	end

	always_comb begin
		dout       = data_q;
		dout.valid = valid_q;
	end

endmodule

[src/bes_div_chain.sv]
module bes_div_chain (
	input  logic              clk,
	input  logic              arst_n,
	input  bes_pkg::bes_div_t din,
	output bes_pkg::bes_div_t dout
);

	bes_pkg::bes_div_t link [bes_pkg::DIV_BITS+1];

	assign link[0] = din;

	for (genvar i = 0; i < bes_pkg::DIV_BITS; i++) begin : g_cell
		bes_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (link[i]),
			.dout   (link[i+1])
		);
	end

	assign dout = link[bes_pkg::DIV_BITS];

endmodule

[src/bezier_easing_sampler.sv]
// A linear curve goes from the accepted beat straight to ST_DONE. Otherwise the block
// runs ST_PREP and ST_COEF, up to MAX_ITER Newton steps through the 40-cell divider
// chain, the final y evaluation and the load of the result into the output register.
// The block takes one item at a time; the next beat is taken once the result is in the
// output register. Reset (arst_n, asynchronous) idles the block and sets the tolerance to 7.
`include "assert_macros.svh"

module bezier_easing_sampler #(
	parameter int TABLE_SIZE = bes_pkg::TABLE_SIZE_DEF,
	parameter int MAX_ITER   = bes_pkg::MAX_ITER_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tol_we,
	input  logic [bes_pkg::TOL_W-1:0] tol_wdata,
	bes_in_if.sink                    sample,
	bes_out_if.source                 result
);

	localparam int ITER_W = $clog2(MAX_ITER + 1);
	localparam int XENT   = 2 ** bes_pkg::IDX_W;
	localparam int WIDE_W = bes_pkg::DIV_BITS + 2;
	localparam logic signed [WIDE_W-1:0] T_MAX =
		{{(WIDE_W - bes_pkg::Q_W){1'b0}}, bes_pkg::ONE_Q16};

	bes_pkg::bes_state_t state_q, state_d;
	bes_pkg::bes_poly_t  poly_q, check_poly;
	logic [1:0]          term_q;
	logic [ITER_W-1:0]   iter_q, iter_nxt;
	logic [bes_pkg::TOL_W-1:0] tol_q;

	logic [bes_pkg::CODE_W-1:0] cx1_q, cy1_q, cx2_q, cy2_q;
	logic [bes_pkg::IDX_W-1:0]  idx_q;
	logic                       lin_q;
	logic [15:0]                x_q;
	bes_pkg::q16_t              px1_q, py1_q, px2_q, py2_q;
	bes_pkg::val_t              ax_q, bx_q, cx_q, ay_q, by_q, cy_q;
	bes_pkg::q16_t              t_q;
	logic signed [bes_pkg::PROD_W-1:0] prod_q, prod_d;
	bes_pkg::val_t              acc_q, acc_d, v_q, v_d, mul_a, addend;
	logic [bes_pkg::VAL_W-1:0]  abs_v;
	logic                       below_tol, last_term, in_lin, out_load;

	bes_pkg::bes_div_t div_in, div_out;
	logic signed [WIDE_W-1:0] quo_s, t_new_s;
	bes_pkg::q16_t            t_clamped;
	bes_pkg::q16_t            y_sat;

	logic                       res_valid_q, res_lin_q;
	bes_pkg::q16_t              res_value_q;
	logic [bes_pkg::IDX_W-1:0]  res_idx_q;

	// Sample points, with indexes past the table end pinned to the last entry.
	logic [15:0] x_tab [XENT];
	for (genvar i = 0; i < XENT; i++) begin : g_x
		localparam int DI = (i < TABLE_SIZE) ? i : TABLE_SIZE - 1;
		localparam int XV = ((2 * DI + 1) * 65536) / (2 * TABLE_SIZE);
		assign x_tab[i] = 16'(XV);
	end

	assign in_lin = (sample.ctrl_x1 == sample.ctrl_y1) && (sample.ctrl_x2 == sample.ctrl_y2);

	// Operand selection for the shared Horner step: acc = floor(m * t) + addend.
	always_comb begin
		mul_a  = acc_q;
		addend = '0;
		if (term_q == 2'd0) begin
			unique case (poly_q)
				bes_pkg::POLY_FX: begin
					mul_a  = ax_q;
					addend = bx_q;
				end
				bes_pkg::POLY_DX: begin
					mul_a  = bes_pkg::val_t'(3 * ax_q);
					addend = bes_pkg::val_t'(2 * bx_q);
				end
				default: begin
					mul_a  = ay_q;
					addend = by_q;
				end
			endcase
		end else if (term_q == 2'd1) begin
			addend = (poly_q == bes_pkg::POLY_FY) ? cy_q : cx_q;
		end
	end

	assign prod_d    = mul_a * $signed({1'b0, t_q});
	assign acc_d     = bes_pkg::val_t'(prod_q >>> 16) + addend;
	assign last_term = (term_q == 2'd2) || ((poly_q == bes_pkg::POLY_DX) && (term_q == 2'd1));

	assign v_d       = acc_q - bes_pkg::val_t'(x_q);
	assign abs_v     = v_d[bes_pkg::VAL_W-1] ? bes_pkg::VAL_W'(-v_d) : bes_pkg::VAL_W'(v_d);
	assign below_tol = abs_v < bes_pkg::VAL_W'(tol_q);

	always_comb begin
		unique case (poly_q)
			bes_pkg::POLY_FX: check_poly = below_tol ? bes_pkg::POLY_FY : bes_pkg::POLY_DX;
			bes_pkg::POLY_DX: check_poly = (acc_q == '0) ? bes_pkg::POLY_FY : bes_pkg::POLY_DX;
			default:          check_poly = bes_pkg::POLY_FY;
		endcase
	end

	// Newton update from the divider result, clamped to 0..1.
	always_comb begin
		quo_s   = div_out.neg ? -$signed({2'b00, div_out.word}) : $signed({2'b00, div_out.word});
		t_new_s = $signed({{(WIDE_W - bes_pkg::Q_W){1'b0}}, t_q}) - quo_s;
		if (t_new_s < 0) begin
			t_clamped = '0;
		end else if (t_new_s > T_MAX) begin
			t_clamped = bes_pkg::ONE_Q16;
		end else begin
			t_clamped = t_new_s[bes_pkg::Q_W-1:0];
		end
		iter_nxt = iter_q + ITER_W'(1);
	end

	always_comb begin
		if (acc_q[bes_pkg::VAL_W-1]) begin
			y_sat = '0;
		end else if (acc_q > bes_pkg::val_t'(bes_pkg::ONE_Q16)) begin
			y_sat = bes_pkg::ONE_Q16;
		end else begin
			y_sat = acc_q[bes_pkg::Q_W-1:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bes_pkg::ST_IDLE: begin
				if (sample.valid) begin
					state_d = in_lin ? bes_pkg::ST_DONE : bes_pkg::ST_PREP;
				end
			end
			bes_pkg::ST_PREP: state_d = bes_pkg::ST_COEF;
			bes_pkg::ST_COEF: state_d = bes_pkg::ST_MUL;
			bes_pkg::ST_MUL:  state_d = bes_pkg::ST_ADD;
			bes_pkg::ST_ADD: begin
				if (!last_term) begin
					state_d = bes_pkg::ST_MUL;
				end else if (poly_q == bes_pkg::POLY_FY) begin
					state_d = bes_pkg::ST_DONE;
				end else begin
					state_d = bes_pkg::ST_CHECK;
				end
			end
			bes_pkg::ST_CHECK: begin
				if (poly_q == bes_pkg::POLY_DX && acc_q != '0) begin
					state_d = bes_pkg::ST_DIV;
				end else begin
					state_d = bes_pkg::ST_MUL;
				end
			end
			bes_pkg::ST_DIV: begin
				if (div_out.valid) begin
					state_d = bes_pkg::ST_MUL;
				end
			end
			bes_pkg::ST_DONE: begin
				if (out_load) begin
					state_d = bes_pkg::ST_IDLE;
				end
			end
			default: state_d = bes_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		sample.ready = (state_q == bes_pkg::ST_IDLE);
		out_load     = (state_q == bes_pkg::ST_DONE) && (!res_valid_q || result.ready);
		div_in       = '0;
		div_in.valid = (state_q == bes_pkg::ST_CHECK) && (poly_q == bes_pkg::POLY_DX)
			&& (acc_q != '0);
		div_in.neg   = v_q[bes_pkg::VAL_W-1] ^ acc_q[bes_pkg::VAL_W-1];
		div_in.word  = {(v_q[bes_pkg::VAL_W-1] ? bes_pkg::VAL_W'(-v_q) : bes_pkg::VAL_W'(v_q)),
			16'h0000};
		div_in.den   = acc_q[bes_pkg::VAL_W-1] ? bes_pkg::DEN_W'(-acc_q) : bes_pkg::DEN_W'(acc_q);
	end

	bes_div_chain u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (div_in),
		.dout   (div_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bes_pkg::ST_IDLE;
			poly_q  <= bes_pkg::POLY_FX;
			term_q  <= '0;
			iter_q  <= '0;
			tol_q   <= bes_pkg::TOL_RESET;
		end else begin
			state_q <= state_d;
			if (tol_we) begin
				tol_q <= tol_wdata;
			end
			unique case (state_q)
				bes_pkg::ST_COEF: begin
					poly_q <= bes_pkg::POLY_FX;
					term_q <= '0;
					iter_q <= '0;
				end
				bes_pkg::ST_ADD: begin
					if (!last_term) begin
						term_q <= term_q + 2'd1;
					end
				end
				bes_pkg::ST_CHECK: begin
					poly_q <= check_poly;
					term_q <= '0;
				end
				bes_pkg::ST_DIV: begin
					if (div_out.valid) begin
						iter_q <= iter_nxt;
						poly_q <= (iter_nxt == ITER_W'(MAX_ITER)) ? bes_pkg::POLY_FY
							: bes_pkg::POLY_FX;
						term_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			bes_pkg::ST_IDLE: begin
				cx1_q <= sample.ctrl_x1;
				cy1_q <= sample.ctrl_y1;
				cx2_q <= sample.ctrl_x2;
				cy2_q <= sample.ctrl_y2;
				idx_q <= sample.sample_index;
				lin_q <= in_lin;
				x_q   <= x_tab[sample.sample_index];
			end
			bes_pkg::ST_PREP: begin
				px1_q <= bes_pkg::CTRL_Q16[cx1_q];
				py1_q <= bes_pkg::CTRL_Q16[cy1_q];
				px2_q <= bes_pkg::CTRL_Q16[cx2_q];
				py2_q <= bes_pkg::CTRL_Q16[cy2_q];
			end
			bes_pkg::ST_COEF: begin
				ax_q <= bes_pkg::val_t'(65536 + 3 * bes_pkg::val_t'(px1_q)
					- 3 * bes_pkg::val_t'(px2_q));
				bx_q <= bes_pkg::val_t'(3 * bes_pkg::val_t'(px2_q) - 6 * bes_pkg::val_t'(px1_q));
				cx_q <= bes_pkg::val_t'(3 * bes_pkg::val_t'(px1_q));
				ay_q <= bes_pkg::val_t'(65536 + 3 * bes_pkg::val_t'(py1_q)
					- 3 * bes_pkg::val_t'(py2_q));
				by_q <= bes_pkg::val_t'(3 * bes_pkg::val_t'(py2_q) - 6 * bes_pkg::val_t'(py1_q));
				cy_q <= bes_pkg::val_t'(3 * bes_pkg::val_t'(py1_q));
				t_q  <= {1'b0, x_q};
			end
			bes_pkg::ST_MUL: prod_q <= prod_d;
			bes_pkg::ST_ADD: acc_q <= acc_d;
			bes_pkg::ST_CHECK: begin
				if (poly_q == bes_pkg::POLY_FX) begin
					v_q <= v_d;
				end
			end
			bes_pkg::ST_DIV: begin
				if (div_out.valid) begin
					t_q <= t_clamped;
				end
			end
			default: ;
		endcase
	end

	// Output register frees the datapath while a finished beat waits downstream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_value_q <= lin_q ? {1'b0, x_q} : y_sat;
			res_lin_q   <= lin_q;
			res_idx_q   <= idx_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.curve_value = res_value_q;
	assign result.is_linear   = res_lin_q;
	assign result.sample_echo = res_idx_q;

	`BES_ASSERT(a_iter_bound, iter_q <= ITER_W'(MAX_ITER))
	`BES_ASSERT(a_div_only_waiting, div_out.valid |-> state_q == bes_pkg::ST_DIV)
	`BES_ASSERT(a_t_range, (state_q == bes_pkg::ST_MUL || state_q == bes_pkg::ST_DIV) |-> t_q <= bes_pkg::ONE_Q16)
	`BES_ASSERT_NEXT(a_load_shows, out_load, result.valid)

endmodule

[test/tb_bezier_easing_sampler.sv]
module tb_bezier_easing_sampler;

	localparam int TBL = 64;
	localparam int ITERS = 8;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [bes_pkg::Q_W-1:0]   value;
		logic                      linear;
		logic [bes_pkg::IDX_W-1:0] index;
	} curve_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic tol_we = 1'b0;
	logic [bes_pkg::TOL_W-1:0] tol_wdata = '0;

	bes_in_if sample_ch();
	bes_out_if result_ch();

	bezier_easing_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.tol_we(tol_we),
		.tol_wdata(tol_wdata),
		.sample(sample_ch.sink),
		.result(result_ch.source)
	);

	always #6 clk = ~clk;

	curve_sample_t pending_samples[$];
	logic [bes_pkg::TOL_W-1:0] tolerance = bes_pkg::TOL_RESET;
	int errors = 0;
	int idle_cycles = 0;
	bit hold_sink = 0;
	bit fast_sink = 0;
	bit fast_source = 0;

	initial begin
		sample_ch.valid = 1'b0;
		sample_ch.ctrl_x1 = '0;
		sample_ch.ctrl_y1 = '0;
		sample_ch.ctrl_x2 = '0;
		sample_ch.ctrl_y2 = '0;
		sample_ch.sample_index = '0;
		result_ch.ready = 1'b0;
	end

	function automatic longint fix_mul(longint a, longint b);
		longint p;
		p = a * b;
		if (p >= 0)
			return p / 65536;
		return -((-p + 65535) / 65536);
	endfunction

	function automatic longint code_q16(logic [bes_pkg::CODE_W-1:0] c);
		return (longint'(c) * 65536 + 63) / 127;
	endfunction

	function automatic longint curve_at(longint t, longint p1, longint p2);
		longint a, b, c;
		a = 65536 + 3 * p1 - 3 * p2;
		b = 3 * p2 - 6 * p1;
		c = 3 * p1;
		return fix_mul(fix_mul(fix_mul(a, t) + b, t) + c, t);
	endfunction

	function automatic longint slope_at(longint t, longint p1, longint p2);
		longint a, b, c;
		a = 65536 + 3 * p1 - 3 * p2;
		b = 3 * p2 - 6 * p1;
		c = 3 * p1;
		return fix_mul(fix_mul(3 * a, t) + 2 * b, t) + c;
	endfunction

	function automatic curve_sample_t ease_sample(logic [bes_pkg::CODE_W-1:0] cx1,
			logic [bes_pkg::CODE_W-1:0] cy1, logic [bes_pkg::CODE_W-1:0] cx2,
			logic [bes_pkg::CODE_W-1:0] cy2, logic [bes_pkg::IDX_W-1:0] idx);
		curve_sample_t r;
		longint d, x, t, y, v, dv, px1, px2;
		d = (idx >= TBL) ? TBL - 1 : idx;
		x = ((2 * d + 1) * 65536) / (2 * TBL);
		r.linear = (cx1 == cy1) && (cx2 == cy2);
		r.index = idx;
		if (r.linear) begin
			y = x;
		end else begin
			px1 = code_q16(cx1);
			px2 = code_q16(cx2);
			t = x;
			for (int k = 0; k < ITERS; k++) begin
				v = curve_at(t, px1, px2) - x;
				if ((v < 0 ? -v : v) < longint'(tolerance))
					break;
				dv = slope_at(t, px1, px2);
				if (dv == 0)
					break;
				t -= (v * 65536) / dv;
				if (t < 0)
					t = 0;
				if (t > 65536)
					t = 65536;
			end
			y = curve_at(t, code_q16(cy1), code_q16(cy2));
		end
		if (y < 0)
			y = 0;
		if (y > 65536)
			y = 65536;
		r.value = y[bes_pkg::Q_W-1:0];
		return r;
	endfunction

	task automatic send_sample(logic [bes_pkg::CODE_W-1:0] cx1, logic [bes_pkg::CODE_W-1:0] cy1,
			logic [bes_pkg::CODE_W-1:0] cx2, logic [bes_pkg::CODE_W-1:0] cy2,
			logic [bes_pkg::IDX_W-1:0] idx);
		int gap;
		gap = fast_source ? 0 : $urandom_range(0, 14);
		// A beat accepted at this very edge still shows valid; the block cannot take
		// another one in the next cycle, so waiting for that edge loses nothing.
		if (sample_ch.valid && gap == 0)
			@(posedge clk);
		repeat (gap) @(posedge clk);
		sample_ch.valid <= 1'b1;
		sample_ch.ctrl_x1 <= cx1;
		sample_ch.ctrl_y1 <= cy1;
		sample_ch.ctrl_x2 <= cx2;
		sample_ch.ctrl_y2 <= cy2;
		sample_ch.sample_index <= idx;
		do @(posedge clk); while (!sample_ch.ready);
		pending_samples.push_back(ease_sample(cx1, cy1, cx2, cy2, idx));
		sample_ch.valid <= 1'b0;
	endtask

	task automatic send_random_curve(int count);
		logic [bes_pkg::CODE_W-1:0] c[4];
		for (int n = 0; n < count; n++) begin
			for (int i = 0; i < 4; i++)
				c[i] = bes_pkg::CODE_W'($urandom_range(0, 127));
			case ($urandom_range(0, 9))
				0: begin c[1] = c[0]; c[3] = c[2]; end
				1: c[$urandom_range(0, 3)] = $urandom_range(0, 1) ? 7'd127 : 7'd0;
				default: ;
			endcase
			send_sample(c[0], c[1], c[2], c[3], bes_pkg::IDX_W'($urandom));
		end
	endtask

	// Wait for every outstanding result, then let the block settle before a write.
	task automatic drain();
		while (pending_samples.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_tolerance(logic [bes_pkg::TOL_W-1:0] tol);
		drain();
		tol_we <= 1'b1;
		tol_wdata <= tol;
		@(posedge clk);
		tol_we <= 1'b0;
		tolerance = tol;
	endtask

	task automatic test_directed();
		send_sample(0, 0, 0, 0, 0);
		send_sample(127, 127, 127, 127, 63);
		send_sample(40, 40, 90, 90, 31);
		send_sample(0, 127, 127, 0, 0);
		send_sample(127, 0, 0, 127, 63);
		send_sample(127, 127, 0, 0, 20);
		send_sample(0, 0, 127, 127, 45);
		send_sample(54, 0, 74, 127, 32);
		send_sample(127, 127, 127, 0, 10);
		send_sample(0, 127, 0, 127, 50);
		send_sample(10, 127, 20, 127, 40);
		send_sample(42, 85, 85, 42, 1);
		send_sample(127, 0, 127, 0, 62);
		send_sample(85, 127, 42, 0, 33);
	endtask

	task automatic test_tolerance_extremes();
		write_tolerance(16'd0);
		send_sample(54, 0, 74, 127, 5);
		send_sample(0, 127, 127, 0, 60);
		send_random_curve(40);
		write_tolerance(16'hFFFF);
		send_sample(54, 0, 74, 127, 5);
		send_random_curve(40);
		write_tolerance(16'h5555);
		send_random_curve(30);
		write_tolerance(16'hAAAA);
		send_random_curve(30);
		write_tolerance(16'd1);
		send_random_curve(40);
	endtask

	task automatic test_backpressure();
		write_tolerance(bes_pkg::TOL_RESET);
		hold_sink = 1;
		fast_source = 1;
		send_random_curve(4);
		fast_source = 0;
		wait (!hold_sink);
		drain();
	endtask

	task automatic test_random();
		write_tolerance(bes_pkg::TOL_W'($urandom));
		for (int phase = 0; phase < 6; phase++) begin
			fast_source = (phase == 2);
			fast_sink = (phase == 2);
			send_random_curve(100);
			write_tolerance(bes_pkg::TOL_W'($urandom_range(0, 64)));
		end
		fast_source = 0;
		fast_sink = 0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tolerance_extremes();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The long hold-off is counted here while the sender keeps offering beats.
	always @(posedge clk) begin
		int wait_n;
		if (hold_sink) begin
			result_ch.ready <= 1'b0;
			repeat (2000) @(posedge clk);
			hold_sink = 0;
		end else if (fast_sink) begin
			result_ch.ready <= 1'b1;
		end else begin
			wait_n = $urandom_range(0, 14);
			if (wait_n != 0) begin
				result_ch.ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid && result_ch.ready) && !hold_sink);
		end
	end

	always @(posedge clk) begin
		curve_sample_t exp_s;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_samples.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual value %0d", $time,
					result_ch.curve_value);
			end else begin
				exp_s = pending_samples.pop_front();
				if (result_ch.curve_value !== exp_s.value) begin
					errors++;
					$display("%0t: curve_value expected %0d actual %0d", $time, exp_s.value,
						result_ch.curve_value);
				end
				if (result_ch.is_linear !== exp_s.linear) begin
					errors++;
					$display("%0t: is_linear expected %0b actual %0b", $time, exp_s.linear,
						result_ch.is_linear);
				end
				if (result_ch.sample_echo !== exp_s.index) begin
					errors++;
					$display("%0t: sample_echo expected %0d actual %0d", $time, exp_s.index,
						result_ch.sample_echo);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
